[hw/rtl/tsum_pkg.sv]
package tsum_pkg;

   localparam int VALUE_W          = 32;
   localparam int MAX_ELEMENTS_DEF = 16;
   localparam int RESULT_LIMIT     = 64;
   localparam int EMIT_W           = $clog2(RESULT_LIMIT + 1);

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_SORT,
      ST_I_CHECK,
      ST_I_DUP,
      ST_LOOP,
      ST_FETCH_LO,
      ST_FETCH_HI,
      ST_COMPARE,
      ST_SKIP_LO,
      ST_SKIP_LO_CMP,
      ST_SKIP_HI,
      ST_SKIP_HI_CMP,
      ST_NEXT_I,
      ST_FINISH
   } tsum_state_type;

   typedef enum logic [1:0] {
      FETCH_NONE,
      FETCH_I,
      FETCH_LO,
      FETCH_HI
   } tsum_fetch_type;

   typedef struct packed {
      logic           load;
      logic           sort_step;
      tsum_fetch_type fetch;
      logic           i_inc;
      logic           ptr_init;
      logic           lo_inc;
      logic           hi_dec;
      logic           match;
      logic           finish;
   } tsum_cmd_type;

   typedef struct packed {
      logic sort_done;
      logic i_ok;
      logic i_dup;
      logic lo_lt_hi;
      logic below_limit;
      logic sum_eq;
      logic sum_gt;
      logic lo_dup;
      logic hi_dup;
      logic out_free;
      logic pend_valid;
   } tsum_sts_type;

endpackage

[hw/rtl/three_sum_two_pointer.sv]
// Channel   Direction  Handshake              Payload
// req       in         req_valid/req_ready    req_value, req_last_element
// rsp       out        rsp_valid/rsp_ready    rsp_smallest, rsp_middle, rsp_largest,
//                                             rsp_found, rsp_truncated, rsp_end_of_run
// csr       in         csr_wr_en              csr_wr_data (target_sum)
//
// Loading takes one beat per cycle while req_ready is high; the beat marked last starts the run.
// Sort: odd-even transposition over the cell row.
// Search: each fixed element is read and, unless equal to its predecessor, sets
// up the pointers; a pointer step fetches both ends, then compares; a match skips
// duplicates, a closing step ends the run; the single cell-row read port orders these.
// A match waits in a holding register until the next one or the end of the run,
// and stalls the search only if the output register is still full then.
// Reset is synchronous; no clearing pass, the store is only read below the count.
module three_sum_two_pointer
   import tsum_pkg::*;
#(
   parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [VALUE_W-1:0] req_value,
   input  logic               req_last_element,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [VALUE_W-1:0] rsp_smallest,
   output logic [VALUE_W-1:0] rsp_middle,
   output logic [VALUE_W-1:0] rsp_largest,
   output logic               rsp_found,
   output logic               rsp_truncated,
   output logic               rsp_end_of_run,
   input  logic               csr_wr_en,
   input  logic [VALUE_W-1:0] csr_wr_data
);

   tsum_cmd_type cmd;
   tsum_sts_type sts;
   logic         last_seen;

   tsum_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .last_seen (last_seen),
      .sts       (sts),
      .cmd       (cmd)
   );

   tsum_dp #(
      .MAX_ELEMENTS (MAX_ELEMENTS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_value        (req_value),
      .req_last_element (req_last_element),
      .last_seen        (last_seen),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_smallest     (rsp_smallest),
      .rsp_middle       (rsp_middle),
      .rsp_largest      (rsp_largest),
      .rsp_found        (rsp_found),
      .rsp_truncated    (rsp_truncated),
      .rsp_end_of_run   (rsp_end_of_run),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .cmd              (cmd),
      .sts              (sts)
   );

endmodule

[hw/rtl/tsum_ctrl.sv]
module tsum_ctrl
   import tsum_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  logic         last_seen,
   input  tsum_sts_type sts,
   output tsum_cmd_type cmd
);

   tsum_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            // the beat marked last kicks off the sort
            if (last_seen) begin
               state_in = ST_SORT;
            end
         end
         ST_SORT: begin
            if (sts.sort_done) begin
               state_in = ST_I_CHECK;
            end
         end
         ST_I_CHECK: begin
            state_in = sts.i_ok ? ST_I_DUP : ST_FINISH;
         end
         ST_I_DUP: begin
            state_in = sts.i_dup ? ST_I_CHECK : ST_LOOP;
         end
         ST_LOOP: begin
            state_in = (sts.lo_lt_hi && sts.below_limit) ? ST_FETCH_LO : ST_NEXT_I;
         end
         ST_FETCH_LO: begin
            state_in = ST_FETCH_HI;
         end
         ST_FETCH_HI: begin
            state_in = ST_COMPARE;
         end
         ST_COMPARE: begin
            if (sts.sum_eq) begin
               if (!sts.pend_valid || sts.out_free) begin
                  state_in = ST_SKIP_LO;
               end
            end else begin
               state_in = ST_LOOP;
            end
         end
         ST_SKIP_LO: begin
            state_in = sts.lo_lt_hi ? ST_SKIP_LO_CMP : ST_SKIP_HI;
         end
         ST_SKIP_LO_CMP: begin
            state_in = sts.lo_dup ? ST_SKIP_LO : ST_SKIP_HI;
         end
         ST_SKIP_HI: begin
            state_in = sts.lo_lt_hi ? ST_SKIP_HI_CMP : ST_LOOP;
         end
         ST_SKIP_HI_CMP: begin
            state_in = sts.hi_dup ? ST_SKIP_HI : ST_LOOP;
         end
         ST_NEXT_I: begin
            state_in = ST_I_CHECK;
         end
         ST_FINISH: begin
            if (sts.out_free) begin
               state_in = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_comb begin
      req_ready     = 1'b0;
      cmd           = '0;
      cmd.fetch     = FETCH_NONE;
      case (state_ff)
         ST_LOAD: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_SORT: begin
            cmd.sort_step = 1'b1;
         end
         ST_I_CHECK: begin
            if (sts.i_ok) begin
               cmd.fetch = FETCH_I;
            end
         end
         ST_I_DUP: begin
            if (sts.i_dup) begin
               cmd.i_inc = 1'b1;
            end else begin
               cmd.ptr_init = 1'b1;
            end
         end
         ST_FETCH_LO: begin
            cmd.fetch = FETCH_LO;
         end
         ST_FETCH_HI: begin
            cmd.fetch = FETCH_HI;
         end
         ST_COMPARE: begin
            if (sts.sum_eq) begin
               cmd.match = !sts.pend_valid || sts.out_free;
            end else if (sts.sum_gt) begin
               cmd.hi_dec = 1'b1;
            end else begin
               cmd.lo_inc = 1'b1;
            end
         end
         ST_SKIP_LO: begin
            if (sts.lo_lt_hi) begin
               cmd.fetch = FETCH_LO;
            end
         end
         ST_SKIP_LO_CMP: begin
            cmd.lo_inc = sts.lo_dup;
         end
         ST_SKIP_HI: begin
            if (sts.lo_lt_hi) begin
               cmd.fetch = FETCH_HI;
            end
         end
         ST_SKIP_HI_CMP: begin
            cmd.hi_dec = sts.hi_dup;
         end
         ST_NEXT_I: begin
            cmd.i_inc = 1'b1;
         end
         ST_FINISH: begin
            cmd.finish = sts.out_free;
         end
         default: begin
            cmd.fetch = FETCH_NONE;
         end
      endcase
   end

endmodule

[hw/rtl/tsum_dp.sv]
module tsum_dp
   import tsum_pkg::*;
#(
   parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [VALUE_W-1:0] req_value,
   input  logic               req_last_element,
   output logic               last_seen,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   output logic [VALUE_W-1:0] rsp_smallest,
   output logic [VALUE_W-1:0] rsp_middle,
   output logic [VALUE_W-1:0] rsp_largest,
   output logic               rsp_found,
   output logic               rsp_truncated,
   output logic               rsp_end_of_run,
   input  logic               csr_wr_en,
   input  logic [VALUE_W-1:0] csr_wr_data,
   input  tsum_cmd_type       cmd,
   output tsum_sts_type       sts
);

   localparam int IDX_W = $clog2(MAX_ELEMENTS);
   localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
   localparam int SUM_W = VALUE_W + 2;

   logic [VALUE_W-1:0] cells_ff [MAX_ELEMENTS];
   logic [VALUE_W-1:0] cells_in [MAX_ELEMENTS];
   logic [MAX_ELEMENTS-2:0] swap;

   logic [CNT_W-1:0]   count_ff, count_in;
   logic               ovf_ff, ovf_in;
   logic [VALUE_W-1:0] target_ff, target_in;
   logic [IDX_W-1:0]   sort_ff, sort_in;
   logic [IDX_W-1:0]   i_ff, i_in;
   logic [IDX_W-1:0]   lo_ff, lo_in;
   logic [IDX_W-1:0]   hi_ff, hi_in;
   logic [EMIT_W-1:0]  emitted_ff, emitted_in;
   logic [VALUE_W-1:0] vi_ff, vi_in;
   logic [VALUE_W-1:0] vprev_ff, vprev_in;
   logic [VALUE_W-1:0] vlo_ff, vlo_in;
   logic [VALUE_W-1:0] vhi_ff, vhi_in;
   logic [VALUE_W-1:0] dup_lo_ff, dup_lo_in;
   logic [VALUE_W-1:0] dup_hi_ff, dup_hi_in;
   logic               pend_valid_ff, pend_valid_in;
   logic [VALUE_W-1:0] pend_a_ff, pend_a_in;
   logic [VALUE_W-1:0] pend_b_ff, pend_b_in;
   logic [VALUE_W-1:0] pend_c_ff, pend_c_in;
   logic               out_valid_ff, out_valid_in;
   logic [VALUE_W-1:0] out_a_ff, out_a_in;
   logic [VALUE_W-1:0] out_b_ff, out_b_in;
   logic [VALUE_W-1:0] out_c_ff, out_c_in;
   logic               out_found_ff, out_found_in;
   logic               out_trunc_ff, out_trunc_in;
   logic               out_end_ff, out_end_in;

   logic               store_full;
   logic               run_start;
   logic               out_free;
   logic [IDX_W-1:0]   rd_addr;
   logic [VALUE_W-1:0] rd_data;
   logic [CNT_W-1:0]   i_plus2;
   logic [SUM_W-1:0]   sum_w;
   logic [SUM_W-1:0]   target_w;

   assign store_full = (count_ff == CNT_W'(MAX_ELEMENTS));
   assign run_start  = cmd.load && req_last_element;
   assign last_seen  = run_start;
   assign out_free   = !out_valid_ff || rsp_ready;

   // single read port into the cell row
   always_comb begin
      case (cmd.fetch)
         FETCH_I:  rd_addr = i_ff;
         FETCH_LO: rd_addr = lo_ff;
         FETCH_HI: rd_addr = hi_ff;
         default:  rd_addr = '0;
      endcase
   end
   assign rd_data = cells_ff[rd_addr];

   // odd-even transposition: even pairs on even phases, odd pairs on odd ones
   always_comb begin
      for (int k = 0; k < MAX_ELEMENTS - 1; k++) begin
         swap[k] = ((k % 2) == int'(sort_ff[0])) && ((k + 1) < int'(count_ff)) &&
                   ($signed(cells_ff[k]) > $signed(cells_ff[k + 1]));
      end
   end

   always_comb begin
      for (int k = 0; k < MAX_ELEMENTS; k++) begin
         cells_in[k] = cells_ff[k];
      end
      if (cmd.load && !store_full) begin
         cells_in[count_ff[IDX_W-1:0]] = req_value;
      end
      if (cmd.sort_step) begin
         for (int k = 0; k < MAX_ELEMENTS - 1; k++) begin
            if (swap[k]) begin
               cells_in[k]     = cells_ff[k + 1];
               cells_in[k + 1] = cells_ff[k];
            end
         end
      end
   end

   assign i_plus2  = CNT_W'(i_ff) + CNT_W'(2);
   assign sum_w    = {{2{vi_ff[VALUE_W-1]}}, vi_ff} + {{2{vlo_ff[VALUE_W-1]}}, vlo_ff} +
                     {{2{vhi_ff[VALUE_W-1]}}, vhi_ff};
   assign target_w = {{2{target_ff[VALUE_W-1]}}, target_ff};

   always_comb begin
      sts.sort_done   = (sort_ff == IDX_W'(MAX_ELEMENTS - 1));
      sts.i_ok        = (i_plus2 < count_ff) && (emitted_ff != EMIT_W'(RESULT_LIMIT));
      sts.i_dup       = (i_ff != '0) && (vi_ff == vprev_ff);
      sts.lo_lt_hi    = (lo_ff < hi_ff);
      sts.below_limit = (emitted_ff != EMIT_W'(RESULT_LIMIT));
      sts.sum_eq      = (sum_w == target_w);
      sts.sum_gt      = ($signed(sum_w) > $signed(target_w));
      sts.lo_dup      = (vlo_ff == dup_lo_ff);
      sts.hi_dup      = (vhi_ff == dup_hi_ff);
      sts.out_free    = out_free;
      sts.pend_valid  = pend_valid_ff;
   end

   always_comb begin
      count_in      = count_ff;
      ovf_in        = ovf_ff;
      target_in     = csr_wr_en ? csr_wr_data : target_ff;
      sort_in       = sort_ff;
      i_in          = i_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      emitted_in    = emitted_ff;
      vi_in         = vi_ff;
      vprev_in      = vprev_ff;
      vlo_in        = vlo_ff;
      vhi_in        = vhi_ff;
      dup_lo_in     = dup_lo_ff;
      dup_hi_in     = dup_hi_ff;
      pend_valid_in = pend_valid_ff;
      pend_a_in     = pend_a_ff;
      pend_b_in     = pend_b_ff;
      pend_c_in     = pend_c_ff;
      out_valid_in  = out_valid_ff && !rsp_ready;
      out_a_in      = out_a_ff;
      out_b_in      = out_b_ff;
      out_c_in      = out_c_ff;
      out_found_in  = out_found_ff;
      out_trunc_in  = out_trunc_ff;
      out_end_in    = out_end_ff;

      if (cmd.load) begin
         if (store_full) begin
            ovf_in = 1'b1;
         end else begin
            count_in = count_ff + CNT_W'(1);
         end
      end
      if (run_start) begin
         sort_in       = '0;
         i_in          = '0;
         emitted_in    = '0;
         pend_valid_in = 1'b0;
      end
      if (cmd.sort_step) begin
         sort_in = sort_ff + IDX_W'(1);
      end

      case (cmd.fetch)
         FETCH_I: begin
            vi_in    = rd_data;
            vprev_in = vi_ff;
         end
         FETCH_LO: vlo_in = rd_data;
         FETCH_HI: vhi_in = rd_data;
         default:  vi_in  = vi_ff;
      endcase

      if (cmd.i_inc) begin
         i_in = i_ff + IDX_W'(1);
      end
      if (cmd.ptr_init) begin
         lo_in = i_ff + IDX_W'(1);
         hi_in = IDX_W'(count_ff - CNT_W'(1));
      end
      if (cmd.lo_inc || cmd.match) begin
         lo_in = lo_ff + IDX_W'(1);
      end
      if (cmd.hi_dec || cmd.match) begin
         hi_in = hi_ff - IDX_W'(1);
      end

      // a match is held back until the next one so the final one can carry end_of_run
      if (cmd.match) begin
         emitted_in    = emitted_ff + EMIT_W'(1);
         dup_lo_in     = vlo_ff;
         dup_hi_in     = vhi_ff;
         pend_valid_in = 1'b1;
         pend_a_in     = vi_ff;
         pend_b_in     = vlo_ff;
         pend_c_in     = vhi_ff;
         if (pend_valid_ff) begin
            out_valid_in = 1'b1;
            out_a_in     = pend_a_ff;
            out_b_in     = pend_b_ff;
            out_c_in     = pend_c_ff;
            out_found_in = 1'b1;
            out_trunc_in = ovf_ff;
            out_end_in   = 1'b0;
         end
      end

      if (cmd.finish) begin
         out_valid_in  = 1'b1;
         out_a_in      = pend_valid_ff ? pend_a_ff : '0;
         out_b_in      = pend_valid_ff ? pend_b_ff : '0;
         out_c_in      = pend_valid_ff ? pend_c_ff : '0;
         out_found_in  = pend_valid_ff;
         out_trunc_in  = ovf_ff;
         out_end_in    = 1'b1;
         count_in      = '0;
         ovf_in        = 1'b0;
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         ovf_ff        <= 1'b0;
         target_ff     <= '0;
         sort_ff       <= '0;
         i_ff          <= '0;
         emitted_ff    <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         count_ff      <= count_in;
         ovf_ff        <= ovf_in;
         target_ff     <= target_in;
         sort_ff       <= sort_in;
         i_ff          <= i_in;
         emitted_ff    <= emitted_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < MAX_ELEMENTS; k++) begin
         cells_ff[k] <= cells_in[k];
      end
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      vi_ff        <= vi_in;
      vprev_ff     <= vprev_in;
      vlo_ff       <= vlo_in;
      vhi_ff       <= vhi_in;
      dup_lo_ff    <= dup_lo_in;
      dup_hi_ff    <= dup_hi_in;
      pend_a_ff    <= pend_a_in;
      pend_b_ff    <= pend_b_in;
      pend_c_ff    <= pend_c_in;
      out_a_ff     <= out_a_in;
      out_b_ff     <= out_b_in;
      out_c_ff     <= out_c_in;
      out_found_ff <= out_found_in;
      out_trunc_ff <= out_trunc_in;
      out_end_ff   <= out_end_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_smallest   = out_a_ff;
   assign rsp_middle     = out_b_ff;
   assign rsp_largest    = out_c_ff;
   assign rsp_found      = out_found_ff;
   assign rsp_truncated  = out_trunc_ff;
   assign rsp_end_of_run = out_end_ff;

`ifndef ASSERT_OFF
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_ELEMENTS))
      else $error("element count beyond capacity");

   a_emit_limit: assert property (@(posedge clock) disable iff (reset)
      emitted_ff <= EMIT_W'(RESULT_LIMIT))
      else $error("result count beyond limit");

   a_match_no_clobber: assert property (@(posedge clock) disable iff (reset)
      cmd.match && pend_valid_ff |-> out_free)
      else $error("held match pushed into a busy output register");

   a_finish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> count_ff == '0 && !pend_valid_ff && out_valid_ff && out_end_ff)
      else $error("run close did not flag the last beat or clear the set");
`endif

endmodule

[tb/three_sum_checker.sv]
module three_sum_checker
   import tsum_pkg::*;
#(
   parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [VALUE_W-1:0] req_value,
   input  logic               req_last_element,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic [VALUE_W-1:0] rsp_smallest,
   input  logic [VALUE_W-1:0] rsp_middle,
   input  logic [VALUE_W-1:0] rsp_largest,
   input  logic               rsp_found,
   input  logic               rsp_truncated,
   input  logic               rsp_end_of_run,
   input  logic               csr_wr_en,
   input  logic [VALUE_W-1:0] csr_wr_data,
   output int                 expected_left,
   output int                 mismatches
);

   typedef struct packed {
      logic [VALUE_W-1:0] smallest;
      logic [VALUE_W-1:0] middle;
      logic [VALUE_W-1:0] largest;
      logic               found;
      logic               truncated;
      logic               end_of_run;
   } triple_beat_type;

   logic signed [VALUE_W-1:0] target_sum;
   logic signed [VALUE_W-1:0] set_values [MAX_ELEMENTS];
   int                        set_size;
   logic                      set_overflow;
   triple_beat_type           triples_due [$];

   task automatic report_mismatch(input string what, input logic [VALUE_W-1:0] got,
                                  input logic [VALUE_W-1:0] want);
      $display("mismatch on %s: got %0d, expected %0d", what, $signed(got), $signed(want));
      mismatches++;
   endtask

   // sort, then fix each element and walk two pointers inward over the rest
   task automatic queue_triples();
      longint          v [MAX_ELEMENTS];
      longint          t;
      longint          s;
      longint          swap;
      int              n;
      int              i;
      int              j;
      int              lo;
      int              hi;
      triple_beat_type beat;
      triple_beat_type hits [$];
      n = set_size;
      for (i = 0; i < n; i++) v[i] = set_values[i];
      for (i = 0; i < n; i++) begin
         for (j = 0; j + 1 < n - i; j++) begin
            if (v[j] > v[j + 1]) begin
               swap = v[j];
               v[j] = v[j + 1];
               v[j + 1] = swap;
            end
         end
      end
      t = target_sum;
      beat = '0;
      beat.truncated = set_overflow;
      for (i = 0; i + 2 < n && hits.size() < RESULT_LIMIT; i++) begin
         if (i > 0 && v[i] == v[i - 1]) continue;
         lo = i + 1;
         hi = n - 1;
         while (lo < hi && hits.size() < RESULT_LIMIT) begin
            s = v[i] + v[lo] + v[hi];
            if (s == t) begin
               beat.smallest = VALUE_W'(v[i]);
               beat.middle   = VALUE_W'(v[lo]);
               beat.largest  = VALUE_W'(v[hi]);
               beat.found    = 1'b1;
               hits.push_back(beat);
               lo++;
               hi--;
               while (lo < hi && v[lo] == v[lo - 1]) lo++;
               while (lo < hi && v[hi] == v[hi + 1]) hi--;
            end else if (s > t) begin
               hi--;
            end else begin
               lo++;
            end
         end
      end
      if (hits.size() == 0) begin
         // not-found beat: zero triple, found low
         hits.push_back(beat);
      end
      foreach (hits[k]) begin
         beat = hits[k];
         beat.end_of_run = (k == hits.size() - 1);
         triples_due.push_back(beat);
      end
   endtask

   always @(posedge clock) begin
      triple_beat_type want;
      if (reset) begin
         target_sum   = '0;
         set_size     = 0;
         set_overflow = 1'b0;
         triples_due.delete();
      end else begin
         if (csr_wr_en) target_sum = csr_wr_data;
         if (req_valid && req_ready) begin
            if (set_size < MAX_ELEMENTS) begin
               set_values[set_size] = req_value;
               set_size++;
            end else begin
               set_overflow = 1'b1;
            end
            if (req_last_element) begin
               queue_triples();
               set_size     = 0;
               set_overflow = 1'b0;
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (triples_due.size() == 0) begin
               $display("mismatch: result beat with nothing expected");
               mismatches++;
            end else begin
               want = triples_due.pop_front();
               if (rsp_smallest !== want.smallest)
                  report_mismatch("smallest", rsp_smallest, want.smallest);
               if (rsp_middle !== want.middle)
                  report_mismatch("middle", rsp_middle, want.middle);
               if (rsp_largest !== want.largest)
                  report_mismatch("largest", rsp_largest, want.largest);
               if (rsp_found !== want.found)
                  report_mismatch("found", rsp_found, want.found);
               if (rsp_truncated !== want.truncated)
                  report_mismatch("truncated", rsp_truncated, want.truncated);
               if (rsp_end_of_run !== want.end_of_run)
                  report_mismatch("end_of_run", rsp_end_of_run, want.end_of_run);
            end
         end
      end
      expected_left <= triples_due.size();
   end

endmodule

[tb/three_sum_two_pointer_test.sv]
module three_sum_two_pointer_test;
   import tsum_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int SETTLE_CYCLES  = 40;
   localparam int RANDOM_ITEMS   = 235;
   localparam logic [VALUE_W-1:0] VALUE_MIN = 32'h8000_0000;
   localparam logic [VALUE_W-1:0] VALUE_MAX = 32'h7FFF_FFFF;

   logic               clock            = 1'b0;
   logic               reset            = 1'b1;
   logic               req_valid        = 1'b0;
   logic               req_ready;
   logic [VALUE_W-1:0] req_value        = '0;
   logic               req_last_element = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready        = 1'b0;
   logic [VALUE_W-1:0] rsp_smallest;
   logic [VALUE_W-1:0] rsp_middle;
   logic [VALUE_W-1:0] rsp_largest;
   logic               rsp_found;
   logic               rsp_truncated;
   logic               rsp_end_of_run;
   logic               csr_wr_en        = 1'b0;
   logic [VALUE_W-1:0] csr_wr_data      = '0;

   int                 expected_left;
   int                 mismatches;
   int                 idle_cycles      = 0;
   int                 stall_left       = 0;
   bit                 ready_steady     = 1'b0;
   int                 random_items     = 0;
   logic [VALUE_W-1:0] set_beats [$];

   three_sum_two_pointer #(.MAX_ELEMENTS(MAX_ELEMENTS_DEF)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_value(req_value), .req_last_element(req_last_element),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_smallest(rsp_smallest), .rsp_middle(rsp_middle), .rsp_largest(rsp_largest),
      .rsp_found(rsp_found), .rsp_truncated(rsp_truncated),
      .rsp_end_of_run(rsp_end_of_run),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   three_sum_checker #(.MAX_ELEMENTS(MAX_ELEMENTS_DEF)) triple_check (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_value(req_value), .req_last_element(req_last_element),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_smallest(rsp_smallest), .rsp_middle(rsp_middle), .rsp_largest(rsp_largest),
      .rsp_found(rsp_found), .rsp_truncated(rsp_truncated),
      .rsp_end_of_run(rsp_end_of_run),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .expected_left(expected_left), .mismatches(mismatches)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 9);
      if (r < 6) return 0;
      if (r < 9) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [VALUE_W-1:0] pick_small();
      int v;
      v = int'($urandom_range(0, 12)) - 6;
      return v;
   endfunction

   function automatic logic [VALUE_W-1:0] pick_value(input int style);
      int r;
      r = $urandom_range(0, 15);
      if (style == 0 || r == 0) return $urandom;
      if (style == 1 && r < 8) begin
         case ($urandom_range(0, 3))
            0: return VALUE_MIN;
            1: return VALUE_MAX;
            2: return '1;
            default: return '0;
         endcase
      end
      return pick_small();
   endfunction

   function automatic logic [VALUE_W-1:0] pick_target();
      case ($urandom_range(0, 9))
         0: return VALUE_MIN;
         1: return VALUE_MAX;
         2: return $urandom;
         default: return pick_small();
      endcase
   endfunction

   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if (!ready_steady) stall_left <= pick_gap();
      end
      if ($urandom_range(0, 199) == 0) ready_steady <= ~ready_steady;
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // valid is only dropped ahead of a gap, so back-to-back beats keep it high
   task automatic send_beat(input logic [VALUE_W-1:0] value, input logic last,
                            input bit steady);
      int gap;
      gap = steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_value        <= value;
      req_last_element <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic send_set(input bit steady);
      foreach (set_beats[k]) send_beat(set_beats[k], k == set_beats.size() - 1, steady);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_left != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_target(input logic [VALUE_W-1:0] value);
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      int size;
      int r;
      int style;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // target still at its reset value of zero
      set_beats = '{32'h1, 32'hFFFF_FFFF, 32'h0};
      send_set(1'b1);
      // fewer than three elements
      set_beats = '{32'h5, 32'h7};
      send_set(1'b0);
      // repeated triple reported once
      set_beats = '{32'h0, 32'h0, 32'h0, 32'h0};
      send_set(1'b0);

      write_target(VALUE_MAX);
      set_beats = '{32'h0, VALUE_MAX, 32'h0};
      send_set(1'b1);

      // store full: the seventeenth beat, the last one, is dropped
      write_target(VALUE_MIN);
      set_beats = '{VALUE_MIN, 32'h0, 32'h0, VALUE_MAX, VALUE_MAX, 32'h1, 32'hFFFF_FFFF,
                    32'h2, 32'hFFFF_FFFE, 32'h3, 32'hFFFF_FFFD, 32'h7, 32'hFFFF_FFF9,
                    32'd100, 32'hFFFF_FF9C, 32'd42, 32'h9};
      send_set(1'b0);

      while (random_items < RANDOM_ITEMS) begin
         if ($urandom_range(0, 3) == 0) write_target(pick_target());
         r = $urandom_range(0, 9);
         if (r == 0) size = $urandom_range(16, 19);
         else if (r == 1) size = $urandom_range(1, 2);
         else size = $urandom_range(3, 8);
         style = $urandom_range(0, 9);
         set_beats.delete();
         repeat (size) set_beats.push_back(pick_value(style));
         send_set($urandom_range(0, 3) == 0);
         random_items += size;
      end

      write_target('0);
      set_beats = '{32'hFFFF_FFFE, 32'h1, 32'h1, 32'h0, 32'h2, 32'hFFFF_FFFF};
      send_set(1'b0);

      wait_drained();
      if (mismatches == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
